/* hdl/dkfc_pkg.sv */
`timescale 1ns / 1ps
package dkfc_pkg;

  typedef logic [26:0] freq_t;
  typedef logic [27:0] tword_t;
  typedef logic [15:0] word_t;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SCAN = 2'd1,
    OP_FULL = 2'd2
  } dkfc_op_t;

  typedef enum logic [1:0] {
    SHAPE_SINE   = 2'd0,
    SHAPE_TRI    = 2'd1,
    SHAPE_SQUARE = 2'd2
  } wave_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_PHASE    = 2'd1,
    REG_MAXF     = 2'd2
  } reg_idx_t;

  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;
  localparam int STEP_ENTRIES = 8;
  localparam int NUM_SLOTS    = 9;

  localparam word_t CW_B28     = 16'h2000;
  localparam word_t CW_RESET   = 16'h0100;
  localparam word_t CW_OPBITEN = 16'h0020;
  localparam word_t CW_DIV2    = 16'h0008;
  localparam word_t CW_MODE    = 16'h0002;
  localparam word_t FREQ0_SEL  = 16'h4000;
  localparam word_t PHASE_SEL  = 16'hC000;

  // Tuning word = floor(f * 2^21 / 5^9). RECIP_M is floor(2^52 / 5^9), so the
  // estimate (f * RECIP_M) >> 31 is at most one below the exact quotient.
  localparam logic [31:0] RECIP_M     = 32'h89705F41;
  localparam int          RECIP_SHIFT = 31;
  localparam logic [20:0] CLK_DIV     = 21'd1953125;

  localparam logic [15:0] DEBOUNCE_RST = 16'd200;
  localparam freq_t       MAXF_RST     = 27'd125000000;
  localparam freq_t       FREQ_RST     = 27'd10000;
  localparam logic [2:0]  STEP_RST     = 3'd3;

  localparam freq_t STEP_TAB [8] = '{
    27'd1, 27'd10, 27'd100, 27'd1000, 27'd10000, 27'd100000, 27'd1000000,
    27'd10000000
  };

  typedef struct packed {
    logic        full_upd;
    logic        ctrl_first;
    wave_t       wave;
    logic        f1_en;
    freq_t       f1;
    logic        f2_en;
    freq_t       f2;
    logic [11:0] phase;
  } job_t;

  typedef struct packed {
    logic        full_upd;
    logic        ctrl_first;
    wave_t       wave;
    logic        f1_en;
    tword_t      tw1;
    logic        f2_en;
    tword_t      tw2;
    logic [11:0] phase;
  } cmd_t;

  function automatic word_t ctrl_word(input wave_t w);
    word_t c;
    case (w)
      SHAPE_TRI:    c = CW_B28 | CW_MODE;
      SHAPE_SQUARE: c = CW_B28 | CW_OPBITEN | CW_DIV2;
      default:      c = CW_B28;
    endcase
    return c;
  endfunction

endpackage

/* hdl/dkfc_front.sv */
`timescale 1ns / 1ps
module dkfc_front
  import dkfc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_opcode,
  input  logic [3:0]  in_keys_pressed,
  input  logic [15:0] press_gap,
  input  logic [11:0] phase_ofs,
  input  freq_t       max_freq_tenths,
  input  logic        credit_ret,
  output logic        job_vld,
  output job_t        job
);

  localparam int CW = $clog2(DEPTH + 1);

  wave_t       wave_r, wave_nxt;
  freq_t       freq_r, freq_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [31:0] now_r, now_nxt;
  logic [31:0] last_r [4];
  logic [31:0] last_nxt [4];
  logic [CW-1:0] credit_r, credit_nxt;
  logic        job_vld_r, job_vld_nxt;
  job_t        job_r, job_nxt;

  logic        acc;
  dkfc_op_t    op;
  logic [3:0]  ok;
  logic [31:0] elapsed [4];
  freq_t       step_val;
  logic [27:0] up_sum;
  freq_t       up_f;
  freq_t       dn_base;
  freq_t       dn_f;
  wave_t       wave_adv;
  logic [3:0]  step_adv;

  assign full    = (credit_r == '0);
  assign job_vld = job_vld_r;
  assign job     = job_r;

  always_comb begin
    acc      = push && !full;
    op       = dkfc_op_t'(in_opcode);
    step_val = STEP_TAB[step_r];

    for (int k = 0; k < 4; k++) begin
      elapsed[k]  = now_r - last_r[k];
      ok[k]       = in_keys_pressed[k] && (elapsed[k] > 32'(press_gap));
      last_nxt[k] = last_r[k];
    end

    case (wave_r)
      SHAPE_SINE:   wave_adv = SHAPE_TRI;
      SHAPE_TRI:    wave_adv = SHAPE_SQUARE;
      SHAPE_SQUARE: wave_adv = SHAPE_SINE;
      default:      wave_adv = SHAPE_TRI;
    endcase

    // Up saturates at the limit; down then works from the result of up.
    up_sum  = {1'b0, freq_r} + {1'b0, step_val};
    up_f    = (up_sum > {1'b0, max_freq_tenths}) ? max_freq_tenths : up_sum[26:0];
    dn_base = ok[1] ? up_f : freq_r;
    dn_f    = (dn_base > step_val) ? (dn_base - step_val) : 27'd1;

    step_adv = {1'b0, step_r} + 4'd1;
    for (int i = 0; i < 8; i++) begin
      if (step_adv >= 4'(STEP_ENTRIES)) begin
        step_adv = step_adv - 4'(STEP_ENTRIES);
      end
    end

    wave_nxt    = wave_r;
    freq_nxt    = freq_r;
    step_nxt    = step_r;
    now_nxt     = now_r;
    job_vld_nxt = 1'b0;
    job_nxt     = job_r;

    if (acc) begin
      case (op)
        OP_TICK: begin
          now_nxt = now_r + 32'd1;
        end
        OP_SCAN: begin
          for (int k = 0; k < 4; k++) begin
            if (ok[k]) begin
              last_nxt[k] = now_r;
            end
          end
          if (ok[0]) begin
            wave_nxt = wave_adv;
          end
          if (ok[2]) begin
            freq_nxt = dn_f;
          end else if (ok[1]) begin
            freq_nxt = up_f;
          end
          if (ok[3]) begin
            step_nxt = step_adv[2:0];
          end
          job_vld_nxt        = ok[0] || ok[1] || ok[2];
          job_nxt.full_upd   = 1'b0;
          job_nxt.ctrl_first = ok[0];
          job_nxt.wave       = wave_adv;
          job_nxt.f1_en      = ok[1] || ok[2];
          job_nxt.f1         = ok[1] ? up_f : dn_f;
          job_nxt.f2_en      = ok[1] && ok[2];
          job_nxt.f2         = dn_f;
          job_nxt.phase      = phase_ofs;
        end
        OP_FULL: begin
          job_vld_nxt        = 1'b1;
          job_nxt.full_upd   = 1'b1;
          job_nxt.ctrl_first = 1'b0;
          job_nxt.wave       = wave_r;
          job_nxt.f1_en      = 1'b1;
          job_nxt.f1         = freq_r;
          job_nxt.f2_en      = 1'b0;
          job_nxt.f2         = freq_r;
          job_nxt.phase      = phase_ofs;
        end
        default: begin
        end
      endcase
    end

    credit_nxt = CW'(credit_r - CW'(job_vld_nxt) + CW'(credit_ret));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r    <= SHAPE_SINE;
      freq_r    <= FREQ_RST;
      step_r    <= STEP_RST;
      now_r     <= '0;
      credit_r  <= CW'(DEPTH);
      job_vld_r <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        last_r[k] <= '0;
      end
    end else begin
      wave_r    <= wave_nxt;
      freq_r    <= freq_nxt;
      step_r    <= step_nxt;
      now_r     <= now_nxt;
      credit_r  <= credit_nxt;
      job_vld_r <= job_vld_nxt;
      for (int k = 0; k < 4; k++) begin
        last_r[k] <= last_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

endmodule

/* hdl/dkfc_tword.sv */
`timescale 1ns / 1ps
module dkfc_tword
  import dkfc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_vld,
  input  job_t in_job,
  output logic out_vld,
  output cmd_t out_cmd
);

  // Stage one multiplies by the reciprocal, stage two multiplies the estimate
  // back, stage three corrects the estimate by one where the remainder allows.
  logic        s1_vld_r;
  job_t        s1_job_r;
  logic [58:0] s1_p1_r, s1_p2_r;

  logic        s2_vld_r;
  job_t        s2_job_r;
  tword_t      s2_q1_r, s2_q2_r;
  logic [48:0] s2_c1_r, s2_c2_r;

  logic        out_vld_r;
  cmd_t        out_cmd_r;

  tword_t      q1, q2;
  logic [48:0] r1, r2;
  cmd_t        cmd_nxt;

  assign out_vld = out_vld_r;
  assign out_cmd = out_cmd_r;

  always_comb begin
    q1 = s1_p1_r[RECIP_SHIFT +: 28];
    q2 = s1_p2_r[RECIP_SHIFT +: 28];

    r1 = 49'({s2_job_r.f1, 21'b0}) - s2_c1_r;
    r2 = 49'({s2_job_r.f2, 21'b0}) - s2_c2_r;

    cmd_nxt.full_upd   = s2_job_r.full_upd;
    cmd_nxt.ctrl_first = s2_job_r.ctrl_first;
    cmd_nxt.wave       = s2_job_r.wave;
    cmd_nxt.f1_en      = s2_job_r.f1_en;
    cmd_nxt.tw1        = (r1 >= 49'(CLK_DIV)) ? (s2_q1_r + 28'd1) : s2_q1_r;
    cmd_nxt.f2_en      = s2_job_r.f2_en;
    cmd_nxt.tw2        = (r2 >= 49'(CLK_DIV)) ? (s2_q2_r + 28'd1) : s2_q2_r;
    cmd_nxt.phase      = s2_job_r.phase;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= in_vld;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_job_r  <= in_job;
    s1_p1_r   <= 59'(in_job.f1) * 59'(RECIP_M);
    s1_p2_r   <= 59'(in_job.f2) * 59'(RECIP_M);
    s2_job_r  <= s1_job_r;
    s2_q1_r   <= q1;
    s2_q2_r   <= q2;
    s2_c1_r   <= 49'(q1) * 49'(CLK_DIV);
    s2_c2_r   <= 49'(q2) * 49'(CLK_DIV);
    out_cmd_r <= cmd_nxt;
  end

endmodule

/* hdl/dkfc_fifo.sv */
`timescale 1ns / 1ps
module dkfc_fifo
  import dkfc_pkg::*;
#(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic             rd_vld,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign rd_vld  = (count_r != '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      count_r <= CW'(count_r + CW'(wr_en) - CW'(rd_en));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* hdl/dkfc_back.sv */
`timescale 1ns / 1ps
module dkfc_back
  import dkfc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cmd_vld,
  input  cmd_t  cmd,
  output logic  cmd_pop,
  input  logic  pop,
  output logic  empty,
  output word_t out_spi_word,
  output logic  out_last
);

  // One slot per possible word, in the order they leave the block:
  // control (scan), first frequency triple, second frequency triple,
  // phase and control (full update).
  cmd_t                 cur_r, cur_nxt;
  logic [NUM_SLOTS-1:0] rem_r, rem_nxt;
  logic                 out_vld_r, out_vld_nxt;
  word_t                out_word_r, out_word_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 emit;
  logic [NUM_SLOTS-1:0] low;
  logic [NUM_SLOTS-1:0] rem_left;
  logic [NUM_SLOTS-1:0] rem_after;
  logic [NUM_SLOTS-1:0] new_mask;
  word_t                slot_word [NUM_SLOTS];
  word_t                sel_word;

  assign empty        = !out_vld_r;
  assign out_spi_word = out_word_r;
  assign out_last     = out_last_r;

  always_comb begin
    slot_word[0] = ctrl_word(cur_r.wave);
    slot_word[1] = CW_B28 | CW_RESET;
    slot_word[2] = FREQ0_SEL | {2'b00, cur_r.tw1[13:0]};
    slot_word[3] = FREQ0_SEL | {2'b00, cur_r.tw1[27:14]};
    slot_word[4] = CW_B28 | CW_RESET;
    slot_word[5] = FREQ0_SEL | {2'b00, cur_r.tw2[13:0]};
    slot_word[6] = FREQ0_SEL | {2'b00, cur_r.tw2[27:14]};
    slot_word[7] = PHASE_SEL | {4'h0, cur_r.phase};
    slot_word[8] = ctrl_word(cur_r.wave);

    new_mask = {{2{cmd.full_upd}}, {3{cmd.f2_en}}, {3{cmd.f1_en}}, cmd.ctrl_first};

    emit     = (rem_r != '0) && (!out_vld_r || pop);
    low      = rem_r & (~rem_r + NUM_SLOTS'(1));
    rem_left = rem_r & ~low;

    sel_word = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (low[i]) begin
        sel_word = sel_word | slot_word[i];
      end
    end

    rem_after = emit ? rem_left : rem_r;
    cmd_pop   = cmd_vld && (rem_after == '0);
    rem_nxt   = cmd_pop ? new_mask : rem_after;
    cur_nxt   = cmd_pop ? cmd : cur_r;

    out_vld_nxt  = out_vld_r;
    out_word_nxt = out_word_r;
    out_last_nxt = out_last_r;
    if (emit) begin
      out_vld_nxt  = 1'b1;
      out_word_nxt = sel_word;
      out_last_nxt = (rem_left == '0);
    end else if (pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      rem_r     <= rem_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

/* hdl/dds_keypad_frequency_controller.sv */
`timescale 1ns / 1ps
// Channel  | Ports                                   | Beat taken when
// input    | push, full, in_opcode, in_keys_pressed  | push && !full
// result   | pop, empty, out_spi_word, out_last      | pop && !empty
// config   | psel, penable, pwrite, paddr, pwdata    | psel && penable && pwrite
//
// The first word of a scan or full update reaches the result ports through
// the job register of the front, three tuning-word stages, the queue, the
// slot register of the back and its output register. Then one word per
// cycle while pop is held high, with up to seven words per item.
// full rises while QUEUE_DEPTH word-producing items are in flight; ticks wait too.
// Reset is synchronous; no clearing pass is needed.
module dds_keypad_frequency_controller
  import dkfc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_opcode,
  input  logic [3:0]        in_keys_pressed,
  output logic              empty,
  input  logic              pop,
  output logic [15:0]       out_spi_word,
  output logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CMD_W = $bits(cmd_t);

  logic [15:0] debounce_r;
  logic [11:0] phase_r;
  freq_t       maxf_r;

  reg_idx_t    reg_idx;
  logic        cfg_wr;

  logic        job_vld;
  job_t        job;
  logic        cmd_in_vld;
  cmd_t        cmd_in;
  logic        cmd_vld;
  logic [CMD_W-1:0] cmd_bits;
  cmd_t        cmd_head;
  logic        cmd_pop;

  assign pready   = 1'b1;
  assign reg_idx  = reg_idx_t'(paddr[3:2]);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cmd_head = cmd_t'(cmd_bits);

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE: prdata = DATA_W'(debounce_r);
      REG_PHASE:    prdata = DATA_W'(phase_r);
      REG_MAXF:     prdata = DATA_W'(maxf_r);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      phase_r    <= '0;
      maxf_r     <= MAXF_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEBOUNCE: debounce_r <= pwdata[15:0];
        REG_PHASE:    phase_r    <= pwdata[11:0];
        REG_MAXF:     maxf_r     <= pwdata[26:0];
        default: begin
        end
      endcase
    end
  end

  dkfc_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_opcode       (in_opcode),
    .in_keys_pressed (in_keys_pressed),
    .press_gap       (debounce_r),
    .phase_ofs       (phase_r),
    .max_freq_tenths (maxf_r),
    .credit_ret      (cmd_pop),
    .job_vld         (job_vld),
    .job             (job)
  );

  dkfc_tword u_tword (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (job_vld),
    .in_job  (job),
    .out_vld (cmd_in_vld),
    .out_cmd (cmd_in)
  );

  dkfc_fifo #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(CMD_W)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_in_vld),
    .wr_data (cmd_in),
    .rd_en   (cmd_pop),
    .rd_vld  (cmd_vld),
    .rd_data (cmd_bits)
  );

  dkfc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_vld      (cmd_vld),
    .cmd          (cmd_head),
    .cmd_pop      (cmd_pop),
    .pop          (pop),
    .empty        (empty),
    .out_spi_word (out_spi_word),
    .out_last     (out_last)
  );

endmodule
